// File: rtl/int64_to_decimal_ascii_macros.svh
// assertion macros for the decimal ascii converter
`ifndef INT64_TO_DECIMAL_ASCII_MACROS_SVH
`define INT64_TO_DECIMAL_ASCII_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ITOA64_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("itoa64 assertion failed");

// antecedent implies consequent in the next cycle
`define ITOA64_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("itoa64 assertion failed");

`endif

// File: rtl/itoa64_pkg.sv
// constants and types for the decimal ascii converter
package itoa64_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned DIGITS = 20;
   localparam int unsigned BCD_W = 4 * DIGITS;
   localparam int unsigned CNT_W = $clog2(VALUE_W);
   localparam int unsigned ND_W = $clog2(DIGITS + 1);
   localparam int unsigned NEED_W = ND_W + 1;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2d;
   localparam logic [7:0] ASCII_NUL = 8'h00;

   localparam logic STATUS_OK = 1'b0;
   localparam logic STATUS_UNDERSIZED = 1'b1;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);
   localparam logic [ND_W-1:0] ND_FULL = ND_W'(DIGITS);
   localparam logic [ND_W-1:0] ND_ONE = ND_W'(1);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_CONV  = 7'b0000010,
      ST_TRIM  = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_SIGN  = 7'b0010000,
      ST_DIGIT = 7'b0100000,
      ST_TERM  = 7'b1000000
   } state_type;

endpackage

// File: rtl/int64_to_decimal_ascii.sv
// decimal ascii converter for 64-bit unsigned or signed values
//
// request channel: req_valid with req_kind, req_value and req_capacity;
// req_stall is high while a conversion is in progress.
// result channel: rsp_valid with rsp_character, rsp_status and rsp_last,
// one character per transfer, held while rsp_stall is high.
// a request converts its magnitude with a bit-serial shift-and-add-3
// register, one input bit per cycle.
// leading zero digits are then dropped one per cycle, and a capacity
// check follows, which issues the undersized result if needed.
// characters ('-', digits, zero terminator with rsp_last) then leave at
// one per cycle while the receiver takes them; a stall holds the output
// register and pauses the sequence; the next request is taken once the
// terminator has been loaded into the output register.
// reset (synchronous) returns to idle and drops any pending result.
module int64_to_decimal_ascii (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_kind,
   input  logic [itoa64_pkg::VALUE_W-1:0] req_value,
   input  logic [7:0]                      req_capacity,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [7:0]                      rsp_character,
   output logic                            rsp_status,
   output logic                            rsp_last
);
   import itoa64_pkg::*;

   `include "int64_to_decimal_ascii_macros.svh"

   state_type state_ff, state_in;
   logic [VALUE_W-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0] bcd_ff, bcd_in, bcd_adj;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [ND_W-1:0] nd_ff, nd_in;
   logic neg_ff, neg_in;
   logic [7:0] cap_ff, cap_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [7:0] char_ff, char_in;
   logic status_ff, status_in;
   logic last_ff, last_in;
   logic accept;
   logic slot_free;
   logic [NEED_W-1:0] need;
   logic [3:0] top_digit;

   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign need = NEED_W'(nd_ff) + NEED_W'(neg_ff) + NEED_W'(1);

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      nd_in = nd_ff;
      neg_in = neg_ff;
      cap_in = cap_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in = char_ff;
      status_in = status_ff;
      last_in = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in = req_kind && req_value[VALUE_W-1];
               bin_in = (req_kind && req_value[VALUE_W-1]) ? (~req_value + 1'b1) : req_value;
               cap_in = req_capacity;
               bcd_in = '0;
               cnt_in = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[VALUE_W-1]};
            bin_in = {bin_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               nd_in = ND_FULL;
               state_in = ST_TRIM;
            end
         end
         ST_TRIM: begin
            if (top_digit == 4'd0 && nd_ff != ND_ONE) begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               nd_in = nd_ff - 1'b1;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ({{(8-NEED_W){1'b0}}, need} > cap_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  char_in = ASCII_NUL;
                  status_in = STATUS_UNDERSIZED;
                  last_in = 1'b1;
                  state_in = ST_IDLE;
               end
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_DIGIT;
            end
         end
         ST_SIGN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               char_in = ASCII_MINUS;
               status_in = STATUS_OK;
               last_in = 1'b0;
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               char_in = ASCII_ZERO | {4'd0, top_digit};
               status_in = STATUS_OK;
               last_in = 1'b0;
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               nd_in = nd_ff - 1'b1;
               if (nd_ff == ND_ONE) begin
                  state_in = ST_TERM;
               end
            end
         end
         ST_TERM: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               char_in = ASCII_NUL;
               status_in = STATUS_OK;
               last_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
      nd_ff <= nd_in;
      neg_ff <= neg_in;
      cap_ff <= cap_in;
      char_ff <= char_in;
      status_ff <= status_in;
      last_ff <= last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = char_ff;
   assign rsp_status = status_ff;
   assign rsp_last = last_ff;

   `ITOA64_ASSERT_SAME(undersized_is_last, rsp_valid_ff && status_ff, last_ff && char_ff == ASCII_NUL)
   `ITOA64_ASSERT_NEXT(accept_starts_conv, accept, state_ff == ST_CONV)
   `ITOA64_ASSERT_SAME(digit_count_nonzero, state_ff == ST_TRIM || state_ff == ST_DIGIT, nd_ff != '0)

endmodule

// File: tb/tb_int64_to_decimal_ascii.sv
// testbench for the 64-bit decimal ascii converter, with a scoreboard that predicts the text
module tb_int64_to_decimal_ascii;
   timeunit 1ns;
   timeprecision 1ps;

   import itoa64_pkg::*;

   typedef struct packed {
      logic [7:0] character;
      logic       status;
      logic       last;
   } text_byte_type;

   class decimal_text_board;
      text_byte_type expected_text[$];
      int errors = 0;
      int chars_seen = 0;
      int requests = 0;
      int undersized = 0;
      int negatives = 0;

      static function int room_needed(logic kind, logic [63:0] value);
         logic [63:0] mag;
         int n;
         mag = (kind && value[63]) ? 64'd0 - value : value;
         n = 0;
         do begin
            n++;
            mag = mag / 10;
         end while (mag != 0);
         return n + ((kind && value[63]) ? 1 : 0) + 1;
      endfunction

      function int pending();
         return expected_text.size();
      endfunction

      function void note_request(logic kind, logic [63:0] value, logic [7:0] capacity);
         logic neg;
         logic [63:0] mag;
         logic [7:0] digits[$];
         neg = kind && value[63];
         mag = neg ? 64'd0 - value : value;
         requests++;
         if (neg) negatives++;
         if (int'(capacity) < room_needed(kind, value)) begin
            undersized++;
            expected_text.push_back('{character: ASCII_NUL, status: STATUS_UNDERSIZED,
                                      last: 1'b1});
            return;
         end
         do begin
            digits.push_front(ASCII_ZERO + 8'(mag % 10));
            mag = mag / 10;
         end while (mag != 0);
         if (neg)
            expected_text.push_back('{character: ASCII_MINUS, status: STATUS_OK, last: 1'b0});
         foreach (digits[j])
            expected_text.push_back('{character: digits[j], status: STATUS_OK, last: 1'b0});
         expected_text.push_back('{character: ASCII_NUL, status: STATUS_OK, last: 1'b1});
      endfunction

      function void check_char(logic [7:0] ch, logic st, logic lst);
         text_byte_type want;
         chars_seen++;
         if (expected_text.size() == 0) begin
            $error("unexpected result: character %0h status %0b last %0b", ch, st, lst);
            errors++;
            return;
         end
         want = expected_text.pop_front();
         if (ch !== want.character) begin
            $error("character: expected %0h, got %0h", want.character, ch);
            errors++;
         end
         if (st !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, st);
            errors++;
         end
         if (lst !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, lst);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_kind = 1'b0;
   logic [63:0] req_value = 64'd0;
   logic [7:0]  req_capacity = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_character;
   logic        rsp_status;
   logic        rsp_last;

   logic steady = 1'b0;
   decimal_text_board board = new();

   int64_to_decimal_ascii uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_kind(req_kind),
      .req_value(req_value),
      .req_capacity(req_capacity),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_character(rsp_character),
      .rsp_status(rsp_status),
      .rsp_last(rsp_last)
   );

   always #4 clock = ~clock;

   function automatic logic hold_off();
      return !steady && ($urandom_range(0, 99) < 18);
   endfunction

   function automatic logic [63:0] pow10(int n);
      logic [63:0] p;
      p = 64'd1;
      for (int j = 0; j < n; j++) p = p * 10;
      return p;
   endfunction

   task automatic drive_request(input logic kind, input logic [63:0] value,
                                input logic [7:0] capacity);
      while (hold_off()) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_value <= value;
      req_capacity <= capacity;
      do @(posedge clock); while (req_stall);
      board.note_request(kind, value, capacity);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_char(rsp_character, rsp_status, rsp_last);
      rsp_stall <= hold_off();
   end

   initial begin
      logic        k;
      logic [63:0] v;
      int          c;
      int          n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, zero, sign handling and capacity boundaries
      drive_request(1'b0, 64'd0, 8'd2);
      drive_request(1'b0, 64'd0, 8'd1);
      drive_request(1'b0, 64'd0, 8'd0);
      drive_request(1'b1, 64'd0, 8'd2);
      drive_request(1'b0, 64'hffff_ffff_ffff_ffff, 8'd21);
      drive_request(1'b0, 64'hffff_ffff_ffff_ffff, 8'd20);
      drive_request(1'b1, 64'h8000_0000_0000_0000, 8'd21);
      drive_request(1'b1, 64'h8000_0000_0000_0000, 8'd20);
      drive_request(1'b0, 64'h8000_0000_0000_0000, 8'd20);
      drive_request(1'b1, 64'hffff_ffff_ffff_ffff, 8'd3);
      drive_request(1'b1, 64'hffff_ffff_ffff_ffff, 8'd2);
      drive_request(1'b1, 64'h7fff_ffff_ffff_ffff, 8'd20);
      drive_request(1'b1, 64'h7fff_ffff_ffff_ffff, 8'd19);
      drive_request(1'b0, pow10(19), 8'd21);
      drive_request(1'b0, pow10(19) - 1, 8'd20);
      drive_request(1'b0, pow10(19) - 1, 8'd19);
      drive_request(1'b0, 64'd9, 8'd255);
      drive_request(1'b0, 64'd10, 8'd2);
      drive_request(1'b1, 64'd0 - 64'd10, 8'd255);
      drive_request(1'b1, 64'd12345, 8'd6);
      drive_request(1'b1, 64'd0 - 64'd12345, 8'd6);

      for (int i = 0; i < 360; i++) begin
         steady <= (i >= 120 && i < 200);
         if (i == 260) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (board.pending() != 0);
         end
         k = 1'($urandom_range(0, 1));
         n = $urandom_range(1, 19);
         case ($urandom_range(0, 9))
            0, 1, 2: v = {$urandom, $urandom};
            3, 4, 5: v = {$urandom, $urandom} % pow10(n);
            6, 7: begin
               k = 1'b1;
               v = 64'd0 - ({$urandom, $urandom} % pow10(n));
            end
            8: begin
               v = pow10(n) - 64'($urandom_range(0, 1));
               if ($urandom_range(0, 1)) begin
                  k = 1'b1;
                  v = 64'd0 - v;
               end
            end
            default: v = 64'($urandom_range(0, 9));
         endcase
         if ($urandom_range(0, 9) < 3)
            c = $urandom_range(0, 255);
         else
            c = decimal_text_board::room_needed(k, v) + $urandom_range(0, 5) - 2;
         drive_request(k, v, 8'(c));
      end
      req_valid <= 1'b0;
      steady <= 1'b0;

      do @(posedge clock); while (board.pending() != 0);
      repeat (100) @(posedge clock);

      $display("covered %0d conversions: %0d negative, %0d undersized",
               board.requests, board.negatives, board.undersized);
      $display("checked %0d result characters, %0d field errors",
               board.chars_seen, board.errors);
      if (board.errors == 0)
         $display("int64_to_decimal_ascii: match");
      else
         $display("int64_to_decimal_ascii: mismatch");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout");
      $display("int64_to_decimal_ascii: mismatch");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/itoa64_pkg.sv
rtl/int64_to_decimal_ascii.sv
tb/tb_int64_to_decimal_ascii.sv
